### rtl/vpc_pkg.sv
// Shared types, constants and helpers for the Verlet particle constraint engine.
package vpc_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int ADDR_W        = $clog2(MAX_PARTICLES);

  localparam logic [2:0] KIND_WRITE     = 3'd0;
  localparam logic [2:0] KIND_INTEGRATE = 3'd1;
  localparam logic [2:0] KIND_LINK      = 3'd2;
  localparam logic [2:0] KIND_READ      = 3'd3;
  localparam logic [2:0] KIND_ATTRACT   = 3'd4;

  localparam logic [2:0] REG_GRAVITY_X       = 3'd0;
  localparam logic [2:0] REG_GRAVITY_Y       = 3'd1;
  localparam logic [2:0] REG_STEP_TIME_SQ    = 3'd2;
  localparam logic [2:0] REG_WINDOW_WIDTH    = 3'd3;
  localparam logic [2:0] REG_WINDOW_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_BORDER_RESPONSE = 3'd5;

  typedef struct packed {
    logic [2:0]         kind;
    logic [9:0]         first_index;
    logic [9:0]         second_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [30:0]        particle_radius;
    logic               pinned;
    logic [30:0]        rest_length;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         read_index;
    logic signed [31:0] read_x;
    logic signed [31:0] read_y;
    logic               read_pinned;
  } out_item_t;

  typedef struct packed {
    logic [31:0] gravity_x;
    logic [31:0] gravity_y;
    logic [31:0] step_time_squared;
    logic [15:0] right_edge;
    logic [15:0] bottom_edge;
    logic [16:0] border_response;
  } cfg_regs_t;

  typedef struct packed {
    logic [31:0] now_x;
    logic [31:0] now_y;
    logic [31:0] prev_x;
    logic [31:0] prev_y;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [31:0] radius;
    logic        pinned;
  } part_t;

  localparam int PART_W = $bits(part_t);

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) sat32 = 32'h7FFFFFFF;
    else if (v < -40'sh0080000000) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [39:0] sx40(input logic [31:0] v);
    sx40 = $signed({{8{v[31]}}, v});
  endfunction

endpackage

### rtl/vpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/vpc_front.sv
// Front end: accepts input transactions, drops invalid ones, queues the rest.
module vpc_front import vpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  in_item_t   fifo_r [2];
  logic       wr_r, rd_r;
  logic [1:0] count_r;
  logic       kind_ok, idx_ok, push;

  assign in_ready = (count_r != 2'd2);
  assign kind_ok  = (in_data.kind <= KIND_ATTRACT);
  assign idx_ok   = (32'(in_data.first_index) < MAX_PARTICLES) &&
                    ((in_data.kind != KIND_LINK) ||
                     (32'(in_data.second_index) < MAX_PARTICLES));
  assign push     = in_valid && in_ready && kind_ok && idx_ok;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = fifo_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wr_r] <= in_data;
        wr_r         <= ~wr_r;
      end
      if (q_pop) rd_r <= ~rd_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/vpc_back.sv
// Back end: sequencer over the particle memory with shared multiplier,
// bit-serial square root and divider, and the result register.
module vpc_back import vpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_LDA, S_LDB, S_EMIT, S_AT, S_WBA,
    S_IPX, S_IPY, S_IPYA, S_IGX, S_IVX, S_IVY,
    S_LAX, S_LSQX, S_LSQY, S_LSQS, S_LRT, S_LCHK,
    S_LMUL, S_LDINIT, S_LDIV, S_LUPD, S_LWB
  } state_t;

  state_t     state_r;
  in_item_t   cmd_r;
  part_t      pa_r, pb_r, rd_part, wr_part;
  out_item_t  out_r;
  logic       out_valid_r;

  logic [PART_W-1:0] rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;

  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic        mul_neg;
  logic [65:0] prod_r;
  logic        neg_r;

  logic [31:0] mx_r, my_r, e_r, root_r, q_r, qx_r;
  logic        s_r, sx_r, sy_r, axis_r;
  logic [63:0] sq_r, rad_r;
  logic [34:0] rem_r;
  logic [32:0] den_r, drem_r;
  logic [31:0] dnum_r;
  logic [4:0]  cnt_r;

  function automatic logic [33:0] mag34(input logic signed [39:0] v);
    mag34 = v[39] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic signed [39:0] bpush(input logic [31:0] p, input logic [31:0] r,
                                               input logic [15:0] w);
    logic signed [39:0] p40, r40, l40;
    p40 = sx40(p);
    r40 = $signed({8'd0, r});
    l40 = $signed({8'd0, w, 16'd0});
    if (p40 + r40 >= l40) bpush = l40 - p40 - r40;
    else if (p40 < r40) bpush = r40 - p40;
    else bpush = '0;
  endfunction

  // Shared multiplier operands; product lands in prod_r next cycle.
  logic signed [39:0] push_v, accg_v;
  always_comb begin
    push_v  = '0;
    accg_v  = '0;
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_r)
      S_IPX: begin
        push_v  = bpush(pa_r.now_x, pa_r.radius, cfg.right_edge);
        mul_a   = mag34(push_v);
        mul_b   = {15'd0, cfg.border_response};
        mul_neg = push_v[39];
      end
      S_IPY: begin
        push_v  = bpush(pa_r.now_y, pa_r.radius, cfg.bottom_edge);
        mul_a   = mag34(push_v);
        mul_b   = {15'd0, cfg.border_response};
        mul_neg = push_v[39];
      end
      S_IGX: begin
        accg_v  = sx40(sat32(sx40(pa_r.acc_x) + sx40(cfg.gravity_x)));
        mul_a   = mag34(accg_v);
        mul_b   = cfg.step_time_squared;
        mul_neg = accg_v[39];
      end
      S_IVX: begin
        accg_v  = sx40(sat32(sx40(pa_r.acc_y) + sx40(cfg.gravity_y)));
        mul_a   = mag34(accg_v);
        mul_b   = cfg.step_time_squared;
        mul_neg = accg_v[39];
      end
      S_LSQX: begin
        mul_a = {2'd0, mx_r};
        mul_b = mx_r;
      end
      S_LSQY: begin
        mul_a = {2'd0, my_r};
        mul_b = my_r;
      end
      S_LMUL: begin
        mul_a = {2'd0, (axis_r ? my_r : mx_r)};
        mul_b = e_r;
      end
      default: ;
    endcase
  end

  // Rounded, signed views of the last product.
  logic [65:0]        r16_u, r32_u;
  logic signed [39:0] r16, r32;
  assign r16_u = (prod_r + 66'd32768) >> 16;
  assign r32_u = (prod_r + (66'd1 << 31)) >> 32;
  assign r16   = neg_r ? -$signed(40'(r16_u)) : $signed(40'(r16_u));
  assign r32   = neg_r ? -$signed(40'(r32_u)) : $signed(40'(r32_u));

  // Link axis.
  logic signed [39:0] dx, dy;
  logic [33:0]        mxa, mya;
  logic               big;
  assign dx  = sx40(pa_r.now_x) - sx40(pb_r.now_x);
  assign dy  = sx40(pa_r.now_y) - sx40(pb_r.now_y);
  assign mxa = mag34(dx);
  assign mya = mag34(dy);
  assign big = (mxa[33:31] != 3'd0) || (mya[33:31] != 3'd0);

  // Square root and divider steps.
  logic [34:0] rem2, trial;
  logic        rt_ge;
  logic [33:0] drem2;
  logic        dv_ge;
  logic [30:0] rs;
  assign rem2  = {rem_r[32:0], rad_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign rt_ge = (rem2 >= trial);
  assign drem2 = {drem_r, dnum_r[31]};
  assign dv_ge = (drem2 >= {1'b0, den_r});
  assign rs    = cmd_r.rest_length >> s_r;

  // Link moves.
  logic signed [39:0] mvx, mvy;
  assign mvx = sx_r ? -$signed({8'd0, qx_r}) : $signed({8'd0, qx_r});
  assign mvy = sy_r ? -$signed({8'd0, q_r}) : $signed({8'd0, q_r});

  // Attraction.
  logic signed [39:0] atx, aty;
  assign atx = sx40(cmd_r.coord_x) - sx40(pa_r.now_x);
  assign aty = sx40(cmd_r.coord_y) - sx40(pa_r.now_y);

  // Memory ports.
  assign rd_part = part_t'(rdata);
  assign raddr   = (state_r == S_IDLE) ? ADDR_W'(q_item.first_index)
                                       : ADDR_W'(cmd_r.second_index);
  assign we      = (state_r == S_WR) || (state_r == S_WBA) || (state_r == S_LWB);
  assign waddr   = (state_r == S_LWB) ? ADDR_W'(cmd_r.second_index)
                                      : ADDR_W'(cmd_r.first_index);
  always_comb begin
    wr_part = pa_r;
    if (state_r == S_LWB) wr_part = pb_r;
    if (state_r == S_WR) begin
      wr_part.now_x  = cmd_r.coord_x;
      wr_part.now_y  = cmd_r.coord_y;
      wr_part.prev_x = cmd_r.coord_x;
      wr_part.prev_y = cmd_r.coord_y;
      wr_part.acc_x  = cfg.gravity_x;
      wr_part.acc_y  = cfg.gravity_y;
      wr_part.radius = {1'b0, cmd_r.particle_radius};
      wr_part.pinned = cmd_r.pinned;
    end
  end

  vpc_ram #(.WIDTH(PART_W), .DEPTH(MAX_PARTICLES)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_part),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a * mul_b);
    neg_r  <= mul_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one is loaded this cycle.
      if (out_valid_r && out_ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_item;
            state_r <= (q_item.kind == KIND_WRITE) ? S_WR : S_LDA;
          end
        end
        S_WR: state_r <= S_IDLE;
        S_LDA: begin
          pa_r <= rd_part;
          case (cmd_r.kind)
            KIND_READ:      state_r <= S_EMIT;
            KIND_INTEGRATE: state_r <= S_IPX;
            KIND_ATTRACT:   state_r <= S_AT;
            default:        state_r <= S_LDB;
          endcase
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_r.read_index  <= cmd_r.first_index;
            out_r.read_x      <= pa_r.now_x;
            out_r.read_y      <= pa_r.now_y;
            out_r.read_pinned <= pa_r.pinned;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_AT: begin
          pa_r.acc_x <= sat32((atx <<< 3) + (atx <<< 1));
          pa_r.acc_y <= sat32((aty <<< 3) + (aty <<< 1));
          state_r    <= S_WBA;
        end
        S_WBA: state_r <= (cmd_r.kind == KIND_LINK) ? S_LWB : S_IDLE;
        S_IPX: state_r <= S_IPY;
        S_IPY: begin
          pa_r.now_x <= sat32(sx40(pa_r.now_x) + r16);
          state_r    <= S_IPYA;
        end
        S_IPYA: begin
          pa_r.now_y <= sat32(sx40(pa_r.now_y) + r16);
          state_r    <= pa_r.pinned ? S_WBA : S_IGX;
        end
        S_IGX: state_r <= S_IVX;
        S_IVX: begin
          pa_r.prev_x <= pa_r.now_x;
          pa_r.now_x  <= sat32((sx40(pa_r.now_x) <<< 1) - sx40(pa_r.prev_x) + r32);
          state_r     <= S_IVY;
        end
        S_IVY: begin
          pa_r.prev_y <= pa_r.now_y;
          pa_r.now_y  <= sat32((sx40(pa_r.now_y) <<< 1) - sx40(pa_r.prev_y) + r32);
          pa_r.acc_x  <= '0;
          pa_r.acc_y  <= '0;
          state_r     <= S_WBA;
        end
        S_LDB: begin
          pb_r    <= rd_part;
          state_r <= S_LAX;
        end
        S_LAX: begin
          s_r     <= big;
          sx_r    <= dx[39];
          sy_r    <= dy[39];
          mx_r    <= big ? mxa[32:1] : mxa[31:0];
          my_r    <= big ? mya[32:1] : mya[31:0];
          state_r <= S_LSQX;
        end
        S_LSQX: state_r <= S_LSQY;
        S_LSQY: begin
          sq_r    <= prod_r[63:0];
          state_r <= S_LSQS;
        end
        S_LSQS: begin
          rad_r   <= sq_r + prod_r[63:0];
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_LRT;
        end
        S_LRT: begin
          rem_r  <= rt_ge ? rem2 - trial : rem2;
          root_r <= {root_r[30:0], rt_ge};
          rad_r  <= rad_r << 2;
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_LCHK;
        end
        S_LCHK: begin
          if ((root_r == 32'd0) || (root_r <= {1'b0, rs})) begin
            state_r <= S_IDLE;
          end else begin
            e_r     <= root_r - {1'b0, rs};
            den_r   <= s_r ? {1'b0, root_r} : {root_r, 1'b0};
            axis_r  <= 1'b0;
            state_r <= S_LMUL;
          end
        end
        S_LMUL: state_r <= S_LDINIT;
        S_LDINIT: begin
          drem_r  <= {1'b0, prod_r[63:32]};
          dnum_r  <= prod_r[31:0];
          cnt_r   <= '0;
          state_r <= S_LDIV;
        end
        S_LDIV: begin
          drem_r <= dv_ge ? 33'(drem2 - {1'b0, den_r}) : drem2[32:0];
          dnum_r <= dnum_r << 1;
          q_r    <= {q_r[30:0], dv_ge};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            if (!axis_r) begin
              qx_r    <= {q_r[30:0], dv_ge};
              axis_r  <= 1'b1;
              state_r <= S_LMUL;
            end else begin
              state_r <= S_LUPD;
            end
          end
        end
        S_LUPD: begin
          if (!pa_r.pinned) begin
            pa_r.now_x <= sat32(sx40(pa_r.now_x) - mvx);
            pa_r.now_y <= sat32(sx40(pa_r.now_y) - mvy);
          end
          if (!pb_r.pinned) begin
            pb_r.now_x <= sat32(sx40(pb_r.now_x) + mvx);
            pb_r.now_y <= sat32(sx40(pb_r.now_y) + mvy);
          end
          state_r <= S_WBA;
        end
        S_LWB: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/verlet_particle_constraint_engine.sv
// Top level of the Verlet particle constraint engine: configuration registers and the two halves.
//
// Particle engine over a 1024-entry particle memory (position, previous position,
// acceleration, radius, static flag), all values signed Q16.16. A front end takes one
// transaction per cycle while the queue has room, into a two-deep queue, dropping unused
// kinds and out-of-range indexes at once; a back end sequences each queued transaction,
// one at a time, through one memory read port and one write port. A read waits while
// the result register is still full. The link path runs a bit-serial square root and
// two bit-serial divides, and shares one 34x32 multiplier with the integrate path. The
// particle memory is not cleared: a read of a particle never written returns anything.
// The configuration port is always ready; write it only while the engine is idle.
module verlet_particle_constraint_engine import vpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t cfg_r;
  logic      q_valid, q_pop;
  in_item_t  q_item;

  assign cfg_ready = 1'b1;

  // Hold register values; take a transaction on any handshake, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_x         <= 32'd0;
      cfg_r.gravity_y         <= 32'd65536000;
      cfg_r.step_time_squared <= 32'd1193046;
      cfg_r.right_edge        <= 16'd1000;
      cfg_r.bottom_edge       <= 16'd1000;
      cfg_r.border_response   <= 17'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GRAVITY_X:       cfg_r.gravity_x         <= cfg_data;
        REG_GRAVITY_Y:       cfg_r.gravity_y         <= cfg_data;
        REG_STEP_TIME_SQ:    cfg_r.step_time_squared <= cfg_data;
        REG_WINDOW_WIDTH:    cfg_r.right_edge        <= cfg_data[15:0];
        REG_WINDOW_HEIGHT:   cfg_r.bottom_edge       <= cfg_data[15:0];
        REG_BORDER_RESPONSE: cfg_r.border_response   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify.
  vpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back end: memory sequencer and arithmetic.
  vpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/vpc_checker.sv
// Watches the engine's channels, predicts each read result and compares it.
module vpc_checker import vpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_reads
);

  logic signed [31:0] grav_x, grav_y;
  logic [31:0]        dt_sq;
  logic [15:0]        win_w, win_h;
  logic [16:0]        resp;

  logic signed [31:0] pos_x [MAX_PARTICLES];
  logic signed [31:0] pos_y [MAX_PARTICLES];
  logic signed [31:0] old_x [MAX_PARTICLES];
  logic signed [31:0] old_y [MAX_PARTICLES];
  logic signed [31:0] acc_x [MAX_PARTICLES];
  logic signed [31:0] acc_y [MAX_PARTICLES];
  logic [31:0]        rad   [MAX_PARTICLES];
  logic               fixed [MAX_PARTICLES];

  out_item_t read_q[$];

  assign pending_reads = read_q.size();

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // magnitude times k, shifted with round half away from zero
  function automatic longint scale_round(input longint v, input longint unsigned k,
                                         input int sh);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = (m * k + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint wall_push(input longint p, input longint r, input longint lim);
    if (p + r >= lim) return -(p - lim + r);
    if (p < r) return -(p - r);
    return 0;
  endfunction

  task automatic step_particle(input int i);
    longint x, y, ax, ay, vx, vy;
    x = pos_x[i];
    y = pos_y[i];
    pos_x[i] = clamp32(x + scale_round(wall_push(x, rad[i], longint'(win_w) * 65536),
                                       resp, 16));
    pos_y[i] = clamp32(y + scale_round(wall_push(y, rad[i], longint'(win_h) * 65536),
                                       resp, 16));
    if (fixed[i]) return;
    ax = clamp32(longint'(acc_x[i]) + grav_x);
    ay = clamp32(longint'(acc_y[i]) + grav_y);
    vx = longint'(pos_x[i]) - old_x[i];
    vy = longint'(pos_y[i]) - old_y[i];
    old_x[i] = pos_x[i];
    old_y[i] = pos_y[i];
    pos_x[i] = clamp32(longint'(pos_x[i]) + vx + scale_round(ax, dt_sq, 32));
    pos_y[i] = clamp32(longint'(pos_y[i]) + vy + scale_round(ay, dt_sq, 32));
    acc_x[i] = 0;
    acc_y[i] = 0;
  endtask

  task automatic pull_pair(input int a, input int b, input longint unsigned rest);
    longint dx, dy, mvx, mvy;
    longint unsigned mx, my, d, rs, e, den;
    int s;
    dx = longint'(pos_x[a]) - pos_x[b];
    dy = longint'(pos_y[a]) - pos_y[b];
    mx = (dx < 0) ? longint'(-dx) : longint'(dx);
    my = (dy < 0) ? longint'(-dy) : longint'(dy);
    s = (mx >= 64'h80000000 || my >= 64'h80000000) ? 1 : 0;
    mx >>= s;
    my >>= s;
    d = root64(mx * mx + my * my);
    rs = rest >> s;
    if (d == 0 || d <= rs) return;
    e = d - rs;
    den = d << (1 - s);
    mvx = longint'(mx * e / den);
    mvy = longint'(my * e / den);
    if (dx < 0) mvx = -mvx;
    if (dy < 0) mvy = -mvy;
    if (!fixed[a]) begin
      pos_x[a] = clamp32(longint'(pos_x[a]) - mvx);
      pos_y[a] = clamp32(longint'(pos_y[a]) - mvy);
    end
    if (!fixed[b]) begin
      pos_x[b] = clamp32(longint'(pos_x[b]) + mvx);
      pos_y[b] = clamp32(longint'(pos_y[b]) + mvy);
    end
  endtask

  task automatic apply_item(input in_item_t t);
    int i;
    out_item_t r;
    i = t.first_index;
    if (i >= MAX_PARTICLES) return;
    case (t.kind)
      KIND_WRITE: begin
        pos_x[i] = t.coord_x;
        old_x[i] = t.coord_x;
        pos_y[i] = t.coord_y;
        old_y[i] = t.coord_y;
        acc_x[i] = grav_x;
        acc_y[i] = grav_y;
        rad[i] = {1'b0, t.particle_radius};
        fixed[i] = t.pinned;
      end
      KIND_INTEGRATE: step_particle(i);
      KIND_LINK: if (t.second_index < MAX_PARTICLES)
        pull_pair(i, t.second_index, t.rest_length);
      KIND_READ: begin
        r.read_index = t.first_index;
        r.read_x = pos_x[i];
        r.read_y = pos_y[i];
        r.read_pinned = fixed[i];
        read_q = {read_q, r};
      end
      KIND_ATTRACT: begin
        acc_x[i] = clamp32(10 * (longint'(t.coord_x) - pos_x[i]));
        acc_y[i] = clamp32(10 * (longint'(t.coord_y) - pos_y[i]));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      grav_x <= 0;
      grav_y <= 32'sd65536000;
      dt_sq <= 32'd1193046;
      win_w <= 16'd1000;
      win_h <= 16'd1000;
      resp <= 17'd65536;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY_X:       grav_x <= cfg_data;
          REG_GRAVITY_Y:       grav_y <= cfg_data;
          REG_STEP_TIME_SQ:    dt_sq <= cfg_data;
          REG_WINDOW_WIDTH:    win_w <= cfg_data[15:0];
          REG_WINDOW_HEIGHT:   win_h <= cfg_data[15:0];
          REG_BORDER_RESPONSE: resp <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) apply_item(in_data);
      if (out_valid && out_ready) begin
        if (read_q.size() == 0) begin
          $error("unexpected read result index %0d", out_data.read_index);
          fail_count <= fail_count + 1;
        end else begin
          want = read_q.pop_front();
          if (out_data !== want) begin
            if (out_data.read_index !== want.read_index)
              $error("read_index expected %0d got %0d", want.read_index, out_data.read_index);
            if (out_data.read_x !== want.read_x)
              $error("read_x expected %0d got %0d", want.read_x, out_data.read_x);
            if (out_data.read_y !== want.read_y)
              $error("read_y expected %0d got %0d", want.read_y, out_data.read_y);
            if (out_data.read_pinned !== want.read_pinned)
              $error("read_pinned expected %0d got %0d", want.read_pinned,
                     out_data.read_pinned);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### bench/testbench.sv
// Top of the engine bench: clock, reset, stimulus, idling and the verdict.
module testbench;
  import vpc_pkg::*;

  localparam int RANDOM_ITEMS = 1650;
  // Slowest item is a stretched link; add stalls and gaps.
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int POOL = 16;

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_ready;
  in_item_t    in_data;
  logic        out_valid, out_ready;
  out_item_t   out_data;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending_reads;
  longint      cycle_count;

  // Particles loaded so far; reads and links stay on these.
  bit          loaded [MAX_PARTICLES];
  int          loaded_list[$];

  verlet_particle_constraint_engine u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  vpc_checker u_check (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending_reads
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Time out a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the receiver on its own pattern: long open stretches, then bursts of stalls.
  initial begin
    int mode;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 3) != 0;
        default: out_ready <= $urandom_range(0, 4) == 0;
      endcase
    end
  end

  // Send one transaction: hold valid and payload until accepted.
  task automatic send(input in_item_t t);
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (t.kind == KIND_WRITE && t.first_index < MAX_PARTICLES && !loaded[t.first_index]) begin
      loaded[t.first_index] = 1;
      loaded_list = {loaded_list, int'(t.first_index)};
    end
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Drain every read, then let up to three queued stretched links finish before
  // touching registers.
  task automatic wait_idle();
    in_valid <= 0;
    while (pending_reads != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 1100) * 65536 + $urandom_range(0, 65535)
                      - 50 * 65536;
    endcase
  endfunction

  function automatic in_item_t build_item(input logic [2:0] k);
    in_item_t t;
    t.kind = k;
    t.first_index = (loaded_list.size() > 0 && k != KIND_WRITE) ? 10'(pick_loaded())
                    : 10'($urandom_range(0, POOL - 1));
    if ($urandom_range(0, 9) == 0 && k == KIND_WRITE) t.first_index = 10'($urandom());
    t.second_index = loaded_list.size() > 0 ? 10'(pick_loaded()) : t.first_index;
    t.coord_x = rand_coord();
    t.coord_y = rand_coord();
    t.particle_radius = $urandom_range(0, 7) == 0 ? 31'($urandom())
                        : 31'($urandom_range(0, 40 * 65536));
    t.pinned = $urandom_range(0, 4) == 0;
    t.rest_length = $urandom_range(0, 7) == 0 ? 31'($urandom())
                    : 31'($urandom_range(0, 200 * 65536));
    return t;
  endfunction

  task automatic apply_setting(input int which);
    case (which)
      0: begin
        write_reg(REG_GRAVITY_X, 32'h80000000);
        write_reg(REG_GRAVITY_Y, 32'h7FFFFFFF);
        write_reg(REG_STEP_TIME_SQ, 32'hFFFFFFFF);
        write_reg(REG_WINDOW_WIDTH, 32'd65535);
        write_reg(REG_WINDOW_HEIGHT, 32'd1);
        write_reg(REG_BORDER_RESPONSE, 32'd0);
      end
      1: begin
        // Zero window and an out-of-range response are used as written.
        write_reg(REG_GRAVITY_X, $urandom());
        write_reg(REG_GRAVITY_Y, $urandom());
        write_reg(REG_STEP_TIME_SQ, 32'd0);
        write_reg(REG_WINDOW_WIDTH, 32'd0);
        write_reg(REG_WINDOW_HEIGHT, 32'd0);
        write_reg(REG_BORDER_RESPONSE, 32'h1FFFF);
      end
      default: begin
        write_reg(REG_GRAVITY_X, $urandom_range(0, 200 * 65536) - 100 * 65536);
        write_reg(REG_GRAVITY_Y, $urandom_range(0, 2000) * 65536);
        write_reg(REG_STEP_TIME_SQ, $urandom_range(0, 4000000));
        write_reg(REG_WINDOW_WIDTH, $urandom_range(1, 1200));
        write_reg(REG_WINDOW_HEIGHT, $urandom_range(1, 1200));
        write_reg(REG_BORDER_RESPONSE, $urandom_range(0, 65536));
      end
    endcase
  endtask

  initial begin
    in_item_t t;
    int burst, phase, sent;
    logic [2:0] k;
    cycle_count = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = REG_GRAVITY_X;
    cfg_data = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, every kind, ignored items, large link axis.
    t = build_item(KIND_WRITE);
    t.first_index = 0; t.coord_x = 32'h7FFFFFFF; t.coord_y = 32'h7FFFFFFF;
    t.particle_radius = 31'h7FFFFFFF; t.pinned = 0;
    send(t);
    t.first_index = 1; t.coord_x = 32'h80000000; t.coord_y = 32'h80000000;
    t.particle_radius = 0; t.pinned = 1;
    send(t);
    t.first_index = 1023; t.coord_x = 0; t.coord_y = 0; t.pinned = 0;
    send(t);
    t.first_index = 2; t.coord_x = 100 * 65536; t.coord_y = 100 * 65536;
    t.particle_radius = 10 * 65536;
    send(t);
    t.kind = KIND_READ; t.first_index = 0; send(t);
    t.first_index = 1; send(t);
    t.first_index = 1023; send(t);
    t.kind = KIND_LINK; t.first_index = 0; t.second_index = 1; t.rest_length = 0;
    send(t);
    t.second_index = 1023; t.rest_length = 31'h7FFFFFFF; send(t);
    t.first_index = 2; t.second_index = 2; t.rest_length = 0; send(t);
    t.first_index = 2; t.second_index = 1023; t.rest_length = 65536; send(t);
    t.kind = KIND_ATTRACT; t.first_index = 0; t.coord_x = 32'h80000000;
    t.coord_y = 32'h7FFFFFFF; send(t);
    t.kind = KIND_INTEGRATE; send(t);
    t.first_index = 1; send(t);
    t.first_index = 2; send(t);
    t.first_index = 1023; send(t);
    t.kind = 3'd5; send(t);
    t.kind = 3'd7; send(t);
    t.kind = KIND_READ;
    for (int i = 0; i < 3; i++) begin
      t.first_index = 10'(i);
      send(t);
    end
    t.first_index = 1023; send(t);

    // Random phases, each under its own register setting.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      apply_setting(phase < 2 ? phase : 2);
      phase++;
      repeat (40) begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          // Mostly operations on loaded particles, some writes and some noise.
          case ($urandom_range(0, 19))
            0, 1, 2:       k = KIND_WRITE;
            3, 4, 5, 6, 7: k = KIND_INTEGRATE;
            8, 9, 10, 11:  k = KIND_LINK;
            12, 13, 14:    k = KIND_READ;
            15, 16:        k = KIND_ATTRACT;
            default:       k = 3'($urandom_range(0, 7));
          endcase
          if (loaded_list.size() == 0) k = KIND_WRITE;
          t = build_item(k);
          // Reads, integrates, attracts and links act only on loaded particles.
          if (k == KIND_READ || k == KIND_INTEGRATE || k == KIND_ATTRACT || k == KIND_LINK)
            t.first_index = 10'(pick_loaded());
          if (k == KIND_LINK) t.second_index = 10'(pick_loaded());
          send(t);
          sent++;
        end
        if ($urandom_range(0, 3) != 0) pause_sender();
        if (sent >= RANDOM_ITEMS) break;
      end
    end

    in_valid <= 0;
    while (pending_reads != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_reads == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/vpc_pkg.sv
rtl/vpc_ram.sv
rtl/vpc_front.sv
rtl/vpc_back.sv
rtl/verlet_particle_constraint_engine.sv
bench/vpc_checker.sv
bench/testbench.sv
